[src/sdcag_pkg.sv]
// Shared types and constants of the strided 2D copy address generator.
package sdcag_pkg;

   // Fixed field widths.
   localparam int ADDR_BITS = 32;
   localparam int LEN_BITS = 20;
   localparam int FMT_BITS = 8;
   localparam int DCOL_BITS = LEN_BITS + FMT_BITS;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Item opcodes.
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] REG_INPUT_PITCH = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_OUTPUT_PITCH = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LINE_SIZE = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LINE_TOTAL = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_INPUT_FORMAT = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_OUTPUT_FORMAT = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SOURCE_OFFSET = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DEST_OFFSET = 3'd7;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_NOOP = 2'd0,
      KIND_HEADER = 2'd1,
      KIND_PAIR = 2'd2
   } kind_type;

   // Input item.
   typedef struct packed {
      logic opcode;
      logic same_space;
   } req_type;

   // Result item.
   typedef struct packed {
      kind_type kind;
      logic [ADDR_BITS-1:0] src_addr;
      logic [ADDR_BITS-1:0] dst_addr;
      logic [ADDR_BITS-1:0] read_extent;
      logic [ADDR_BITS-1:0] write_extent;
      logic block_transfer;
      logic overlapping;
      logic last;
   } rsp_type;

   // Configuration register contents.
   typedef struct packed {
      logic [31:0] input_pitch;
      logic [31:0] output_pitch;
      logic [LEN_BITS-1:0] line_size;
      logic [LEN_BITS-1:0] line_total;
      logic [FMT_BITS-1:0] input_format;
      logic [FMT_BITS-1:0] output_format;
      logic [ADDR_BITS-1:0] source_offset;
      logic [ADDR_BITS-1:0] dest_offset;
   } cfg_type;

   // Registered transfer extents derived from the configuration.
   typedef struct packed {
      logic [ADDR_BITS-1:0] read_extent;
      logic [ADDR_BITS-1:0] write_extent;
      logic settling;
   } span_type;

endpackage

[src/sdcag_csr.sv]
// Configuration registers and the registered read and write extents.
module sdcag_csr (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [sdcag_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sdcag_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output sdcag_pkg::cfg_type cfg,
   output sdcag_pkg::span_type span
);
   import sdcag_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   span_type span_ff;
   span_type span_in;
   logic [LEN_BITS-1:0] count_m1;
   logic [ADDR_BITS-1:0] rd_prod;
   logic [ADDR_BITS-1:0] wr_prod;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_INPUT_PITCH:   cfg_in.input_pitch = csr_wdata[31:0];
            REG_OUTPUT_PITCH:  cfg_in.output_pitch = csr_wdata[31:0];
            REG_LINE_SIZE:     cfg_in.line_size = csr_wdata[LEN_BITS-1:0];
            REG_LINE_TOTAL:    cfg_in.line_total = csr_wdata[LEN_BITS-1:0];
            REG_INPUT_FORMAT:  cfg_in.input_format = csr_wdata[FMT_BITS-1:0];
            REG_OUTPUT_FORMAT: cfg_in.output_format = csr_wdata[FMT_BITS-1:0];
            REG_SOURCE_OFFSET: cfg_in.source_offset = csr_wdata[ADDR_BITS-1:0];
            REG_DEST_OFFSET:   cfg_in.dest_offset = csr_wdata[ADDR_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Extent is pitch times (count - 1) plus length, modulo the address width.
   // The count minus one wraps to all ones when the count is zero.
   always_comb begin
      count_m1 = cfg_ff.line_total - LEN_BITS'(1);
      rd_prod = cfg_ff.input_pitch * ADDR_BITS'(count_m1);
      wr_prod = cfg_ff.output_pitch * ADDR_BITS'(count_m1);
      span_in.read_extent = rd_prod + ADDR_BITS'(cfg_ff.line_size);
      span_in.write_extent = wr_prod + ADDR_BITS'(cfg_ff.line_size);
      // The registered extents lag the registers after any write.
      span_in.settling = csr_we;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
         span_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
         span_ff <= span_in;
      end
   end

   assign cfg = cfg_ff;
   assign span = span_ff;

endmodule

[src/sdcag_engine.sv]
// Walker state and the per-item result logic.
module sdcag_engine (
   input  logic clock,
   input  logic reset,
   input  sdcag_pkg::cfg_type cfg,
   input  sdcag_pkg::span_type span,
   input  logic advance,
   input  sdcag_pkg::req_type item,
   output logic produce,
   output sdcag_pkg::rsp_type result
);
   import sdcag_pkg::*;

   logic busy_ff, busy_in;
   logic [LEN_BITS-1:0] row_index_ff, row_index_in;
   logic [LEN_BITS-1:0] src_column_ff, src_column_in;
   logic [DCOL_BITS-1:0] dst_column_ff, dst_column_in;
   logic [ADDR_BITS-1:0] src_row_base_ff, src_row_base_in;
   logic [ADDR_BITS-1:0] dst_row_base_ff, dst_row_base_in;

   logic strided;
   logic [FMT_BITS-1:0] src_step;
   logic [FMT_BITS-1:0] dst_step;
   logic [LEN_BITS:0] next_column;
   logic line_done;
   logic final_row;
   logic [ADDR_BITS-1:0] src_max;
   logic [ADDR_BITS-1:0] dst_max;

   // Stride selection and line and transfer end detection.
   always_comb begin
      strided = (|cfg.input_format[FMT_BITS-1:1]) || (|cfg.output_format[FMT_BITS-1:1]);
      src_step = FMT_BITS'(1);
      dst_step = FMT_BITS'(1);
      if (strided) begin
         src_step = (cfg.input_format == '0) ? FMT_BITS'(1) : cfg.input_format;
         dst_step = cfg.output_format;
      end
      next_column = {1'b0, src_column_ff} + (LEN_BITS + 1)'(src_step);
      line_done = !(next_column < {1'b0, cfg.line_size});
      final_row = !(({1'b0, row_index_ff} + (LEN_BITS + 1)'(1)) < {1'b0, cfg.line_total});
      src_max = cfg.source_offset + span.read_extent;
      dst_max = cfg.dest_offset + span.write_extent;
   end

   // Result and next state for the item leaving the input register.
   always_comb begin
      produce = 1'b0;
      result = '0;
      result.kind = KIND_NOOP;
      busy_in = busy_ff;
      row_index_in = row_index_ff;
      src_column_in = src_column_ff;
      dst_column_in = dst_column_ff;
      src_row_base_in = src_row_base_ff;
      dst_row_base_in = dst_row_base_ff;
      if (advance) begin
         case (item.opcode)
            OP_START: begin
               produce = 1'b1;
               if (cfg.line_total == '0 || cfg.line_size == '0) begin
                  busy_in = 1'b0;
                  result.last = 1'b1;
               end else begin
                  result.kind = KIND_HEADER;
                  result.src_addr = cfg.source_offset;
                  result.dst_addr = cfg.dest_offset;
                  result.read_extent = span.read_extent;
                  result.write_extent = span.write_extent;
                  result.block_transfer = (cfg.input_pitch == cfg.output_pitch) &&
                     (cfg.output_pitch == 32'(cfg.line_size));
                  result.overlapping = item.same_space &&
                     ((cfg.source_offset >= cfg.dest_offset && cfg.source_offset < dst_max) ||
                      (cfg.dest_offset >= cfg.source_offset && cfg.dest_offset < src_max));
                  busy_in = 1'b1;
                  row_index_in = '0;
                  src_column_in = '0;
                  dst_column_in = '0;
                  src_row_base_in = cfg.source_offset;
                  dst_row_base_in = cfg.dest_offset;
               end
            end
            OP_STEP: begin
               if (busy_ff) begin
                  produce = 1'b1;
                  result.kind = KIND_PAIR;
                  result.src_addr = src_row_base_ff + ADDR_BITS'(src_column_ff);
                  result.dst_addr = dst_row_base_ff + ADDR_BITS'(dst_column_ff);
                  if (!line_done) begin
                     src_column_in = next_column[LEN_BITS-1:0];
                     dst_column_in = dst_column_ff + DCOL_BITS'(dst_step);
                  end else begin
                     src_column_in = '0;
                     dst_column_in = '0;
                     if (final_row) begin
                        busy_in = 1'b0;
                        row_index_in = '0;
                        result.last = 1'b1;
                     end else begin
                        row_index_in = row_index_ff + LEN_BITS'(1);
                        src_row_base_in = src_row_base_ff + cfg.input_pitch;
                        dst_row_base_in = dst_row_base_ff + cfg.output_pitch;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         row_index_ff <= '0;
         src_column_ff <= '0;
         dst_column_ff <= '0;
         src_row_base_ff <= '0;
         dst_row_base_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         row_index_ff <= row_index_in;
         src_column_ff <= src_column_in;
         dst_column_ff <= dst_column_in;
         src_row_base_ff <= src_row_base_in;
         dst_row_base_ff <= dst_row_base_in;
      end
   end

`ifndef SYNTHESIS
   // A header arms the walker at the first column of the first line.
   a_header_arms: assert property (@(posedge clock) disable iff (reset)
      (produce && result.kind == KIND_HEADER) |=>
         (busy_ff && row_index_ff == '0 && src_column_ff == '0 && dst_column_ff == '0))
      else $error("header did not arm the walker");

   // The final pair ends the transfer.
   a_last_pair_idles: assert property (@(posedge clock) disable iff (reset)
      (produce && result.kind == KIND_PAIR && result.last) |=> !busy_ff)
      else $error("walker still busy after the final pair");

   // A step item while idle gives no result and leaves the walker idle.
   a_idle_step_silent: assert property (@(posedge clock) disable iff (reset)
      (advance && item.opcode == OP_STEP && !busy_ff) |-> (!produce && !busy_in))
      else $error("step while idle produced a result");
`endif

endmodule

[src/strided_2d_copy_address_generator.sv]
// Top level of the strided 2D copy address generator: handshake registers and wiring.
// The block takes one item per cycle when the receiver does not stall and no configuration
// write is settling: an item is held in an input register, the walker state and the result
// are computed combinationally from it, and the result, if any, waits in an output register
// while the next item is taken. The sustained rate of one item per cycle is set by the update
// of the walker state (line bases, column counters and row index) as each item advances. The
// read and write extents are precomputed from the configuration in a registered multiply-add,
// so processing of a held item pauses after each configuration write.
module strided_2d_copy_address_generator (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  sdcag_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output sdcag_pkg::rsp_type rsp_data,
   input  logic csr_we,
   input  logic [sdcag_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sdcag_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import sdcag_pkg::*;

   cfg_type cfg;
   span_type span;

   logic in_valid_ff, in_valid_in;
   req_type in_item_ff, in_item_in;
   logic out_valid_ff, out_valid_in;
   rsp_type out_item_ff, out_item_in;

   logic advance;
   logic produce;
   rsp_type result;

   sdcag_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .span      (span)
   );

   sdcag_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .span    (span),
      .advance (advance),
      .item    (in_item_ff),
      .produce (produce),
      .result  (result)
   );

   // The held item moves on when the output register is free or being emptied and the extents are not settling.
   always_comb begin
      advance = in_valid_ff && !span.settling && (!out_valid_ff || rsp_ready);
      req_ready = !in_valid_ff || advance;
   end

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in = in_item_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_item_in = req_data;
      end
   end

   // Output register.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in = out_item_ff;
      if (advance) begin
         out_valid_in = produce;
         out_item_in = result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_item_ff <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_item_ff;

`ifndef SYNTHESIS
   // An accepted item is held in the input register on the next cycle.
   a_accept_held: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> in_valid_ff)
      else $error("accepted item lost from the input register");

   // A held item that cannot move on keeps its contents.
   a_hold_stable: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("stalled input register changed");

   // Every result the walker produces reaches the output register.
   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      (advance && produce) |=> rsp_valid)
      else $error("produced result not presented");
`endif

endmodule

[sim/strided_2d_copy_address_generator_tb.sv]
// Testbench of the strided 2D copy address generator: directed and random walks checked by a predictor.
module strided_2d_copy_address_generator_tb;
   import sdcag_pkg::*;

   // Cycles with no handshake at all before the run is declared hung.
   localparam int STALL_LIMIT = 1000;
   // Cycles allowed after the last result for items that answer nothing.
   localparam int SETTLE_CYCLES = 4;
   // Long receiver hold-off that fills the block and stalls its input.
   localparam int HOLD_OFF_CYCLES = 120;
   // Counted item totals at which the random and the final streaming parts stop.
   localparam int RANDOM_ITEMS = 1050;
   localparam int TOTAL_ITEMS = 1250;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // Idling chances in percent, and a pending long hold-off for the receiver.
   int send_gap_pct = 0;
   int recv_gap_pct = 0;
   int hold_off_len = 0;

   int walk_items = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   // Mirrored registers and walker state.
   cfg_type shadow_cfg = '0;
   bit walking = 1'b0;
   logic [LEN_BITS-1:0] row_idx = '0;
   logic [LEN_BITS-1:0] src_col = '0;
   logic [DCOL_BITS-1:0] dst_col = '0;
   logic [ADDR_BITS-1:0] src_base = '0;
   logic [ADDR_BITS-1:0] dst_base = '0;

   rsp_type pending_results[$];

   strided_2d_copy_address_generator uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Extent of one side: pitch times (lines - 1) plus line length, modulo the address width.
   function automatic logic [ADDR_BITS-1:0] extent_of(input logic [31:0] pitch);
      logic [LEN_BITS-1:0] rows_less_one;
      rows_less_one = shadow_cfg.line_total - LEN_BITS'(1);
      return pitch * ADDR_BITS'(rows_less_one) + ADDR_BITS'(shadow_cfg.line_size);
   endfunction

   // Works out the result of one accepted item; returns 0 when the item answers nothing.
   function automatic bit predict_walk(input req_type item, output rsp_type res);
      logic [ADDR_BITS-1:0] src_span, dst_span, src_end, dst_end;
      logic [LEN_BITS:0] next_col;
      logic [FMT_BITS-1:0] src_step, dst_step;
      res = '0;
      if (item.opcode == OP_START) begin
         // An empty transfer answers a no-op and drops any running walk.
         if (shadow_cfg.line_total == 0 || shadow_cfg.line_size == 0) begin
            walking = 1'b0;
            res.kind = KIND_NOOP;
            res.last = 1'b1;
            return 1'b1;
         end
         src_span = extent_of(shadow_cfg.input_pitch);
         dst_span = extent_of(shadow_cfg.output_pitch);
         src_end = shadow_cfg.source_offset + src_span;
         dst_end = shadow_cfg.dest_offset + dst_span;
         res.kind = KIND_HEADER;
         res.src_addr = shadow_cfg.source_offset;
         res.dst_addr = shadow_cfg.dest_offset;
         res.read_extent = src_span;
         res.write_extent = dst_span;
         res.block_transfer = shadow_cfg.input_pitch == shadow_cfg.output_pitch &&
                              shadow_cfg.output_pitch == 32'(shadow_cfg.line_size);
         res.overlapping = item.same_space &&
            ((shadow_cfg.source_offset >= shadow_cfg.dest_offset &&
              shadow_cfg.source_offset < dst_end) ||
             (shadow_cfg.dest_offset >= shadow_cfg.source_offset &&
              shadow_cfg.dest_offset < src_end));
         walking = 1'b1;
         row_idx = '0;
         src_col = '0;
         dst_col = '0;
         src_base = shadow_cfg.source_offset;
         dst_base = shadow_cfg.dest_offset;
         return 1'b1;
      end

      // A step with no transfer armed is ignored.
      if (!walking) return 1'b0;

      // Formats act as byte strides once either of them exceeds one.
      src_step = 8'd1;
      dst_step = 8'd1;
      if (shadow_cfg.input_format > 1 || shadow_cfg.output_format > 1) begin
         src_step = (shadow_cfg.input_format == 0) ? 8'd1 : shadow_cfg.input_format;
         dst_step = shadow_cfg.output_format;
      end
      res.kind = KIND_PAIR;
      res.src_addr = src_base + ADDR_BITS'(src_col);
      res.dst_addr = dst_base + ADDR_BITS'(dst_col);

      next_col = {1'b0, src_col} + (LEN_BITS + 1)'(src_step);
      if (next_col < {1'b0, shadow_cfg.line_size}) begin
         src_col = next_col[LEN_BITS-1:0];
         dst_col = dst_col + DCOL_BITS'(dst_step);
         return 1'b1;
      end

      // End of a line: either the transfer is done or the bases move by the pitches.
      src_col = '0;
      dst_col = '0;
      if (shadow_cfg.line_total == 0 || 32'(row_idx) + 32'd1 >= 32'(shadow_cfg.line_total)) begin
         walking = 1'b0;
         row_idx = '0;
         res.last = 1'b1;
         return 1'b1;
      end
      row_idx = row_idx + LEN_BITS'(1);
      src_base = src_base + shadow_cfg.input_pitch;
      dst_base = dst_base + shadow_cfg.output_pitch;
      return 1'b1;
   endfunction

   function automatic void mirror_reg_write(input logic [CSR_INDEX_BITS-1:0] idx,
                                            input logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         REG_INPUT_PITCH: shadow_cfg.input_pitch = data;
         REG_OUTPUT_PITCH: shadow_cfg.output_pitch = data;
         REG_LINE_SIZE: shadow_cfg.line_size = data[LEN_BITS-1:0];
         REG_LINE_TOTAL: shadow_cfg.line_total = data[LEN_BITS-1:0];
         REG_INPUT_FORMAT: shadow_cfg.input_format = data[FMT_BITS-1:0];
         REG_OUTPUT_FORMAT: shadow_cfg.output_format = data[FMT_BITS-1:0];
         REG_SOURCE_OFFSET: shadow_cfg.source_offset = data;
         REG_DEST_OFFSET: shadow_cfg.dest_offset = data;
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [ADDR_BITS-1:0] want,
                                       input logic [ADDR_BITS-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic void compare_result(input rsp_type want, input rsp_type got);
      check_field("kind", ADDR_BITS'(want.kind), ADDR_BITS'(got.kind));
      check_field("src_addr", want.src_addr, got.src_addr);
      check_field("dst_addr", want.dst_addr, got.dst_addr);
      check_field("read_extent", want.read_extent, got.read_extent);
      check_field("write_extent", want.write_extent, got.write_extent);
      check_field("block_transfer", ADDR_BITS'(want.block_transfer),
                  ADDR_BITS'(got.block_transfer));
      check_field("overlapping", ADDR_BITS'(want.overlapping), ADDR_BITS'(got.overlapping));
      check_field("last", ADDR_BITS'(want.last), ADDR_BITS'(got.last));
   endfunction

   // Mirror register writes, check each result and predict each accepted item.
   always @(posedge clock) begin
      rsp_type predicted;
      if (!reset) begin
         if (csr_we) mirror_reg_write(csr_index, csr_wdata);
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("result item with none expected: kind %0d", rsp_data.kind);
               mismatch_count++;
            end else begin
               compare_result(pending_results.pop_front(), rsp_data);
            end
         end
         if (req_valid && req_ready) begin
            if (predict_walk(req_data, predicted)) pending_results.push_back(predicted);
         end
      end
   end

   // Watchdog on cycles in which nothing moves.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == STALL_LIMIT) begin
         $display("strided_2d_copy_address_generator test failed");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off when a test asks for one.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off_len - 1) @(negedge clock);
            hold_off_len = 0;
         end else if ($urandom_range(0, 99) < recv_gap_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 16)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offers one item, with an optional gap first, and returns at the falling edge after acceptance.
   task automatic send_item(input req_type item);
      if ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic start_transfer(input bit same_space);
      send_item(req_type'{opcode: OP_START, same_space: same_space});
      walk_items++;
   endtask

   task automatic step_walk(input int count);
      repeat (count) send_item(req_type'{opcode: OP_STEP, same_space: 1'($urandom_range(0, 1))});
      walk_items += count;
   endtask

   // Drops valid and waits until every expected result has come and the pipeline is empty.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // Writes every register once the block has gone quiet.
   task automatic set_config(input cfg_type c);
      wait_idle();
      write_reg(REG_INPUT_PITCH, c.input_pitch);
      write_reg(REG_OUTPUT_PITCH, c.output_pitch);
      write_reg(REG_LINE_SIZE, CSR_DATA_BITS'(c.line_size));
      write_reg(REG_LINE_TOTAL, CSR_DATA_BITS'(c.line_total));
      write_reg(REG_INPUT_FORMAT, CSR_DATA_BITS'(c.input_format));
      write_reg(REG_OUTPUT_FORMAT, CSR_DATA_BITS'(c.output_format));
      write_reg(REG_SOURCE_OFFSET, c.source_offset);
      write_reg(REG_DEST_OFFSET, c.dest_offset);
      csr_we <= 1'b0;
   endtask

   // Number of address pairs in one full transfer under a setting.
   function automatic int walk_length(input cfg_type c);
      int stride;
      if (c.line_size == 0 || c.line_total == 0) return 0;
      stride = 1;
      if (c.input_format > 1 || c.output_format > 1) begin
         stride = (c.input_format == 0) ? 1 : int'(c.input_format);
      end
      return ((int'(c.line_size) + stride - 1) / stride) * int'(c.line_total);
   endfunction

   function automatic int pick_gap_pct();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 8;
         2: return 25;
         default: return 50;
      endcase
   endfunction

   // Mostly short transfers; some empty ones, strided ones, block copies and nearby ranges.
   function automatic cfg_type random_config();
      cfg_type c;
      c.line_size = ($urandom_range(0, 7) == 0) ? LEN_BITS'($urandom_range(13, 64)) :
                                                  LEN_BITS'($urandom_range(1, 12));
      c.line_total = LEN_BITS'($urandom_range(1, 5));
      if ($urandom_range(0, 11) == 0) begin
         if ($urandom_range(0, 1) == 1) c.line_size = '0;
         else c.line_total = '0;
      end
      case ($urandom_range(0, 4))
         0, 1: begin
            c.input_format = FMT_BITS'($urandom_range(0, 1));
            c.output_format = FMT_BITS'($urandom_range(0, 1));
         end
         2: begin
            c.input_format = FMT_BITS'($urandom_range(0, 6));
            c.output_format = FMT_BITS'($urandom_range(0, 6));
         end
         3: begin
            c.input_format = FMT_BITS'($urandom_range(0, 1));
            c.output_format = FMT_BITS'($urandom_range(2, 255));
         end
         default: begin
            c.input_format = FMT_BITS'($urandom_range(2, 255));
            c.output_format = FMT_BITS'($urandom_range(0, 255));
         end
      endcase
      case ($urandom_range(0, 3))
         0: begin
            c.input_pitch = 32'(c.line_size);
            c.output_pitch = 32'(c.line_size);
         end
         1: begin
            c.input_pitch = 32'(c.line_size);
            c.output_pitch = int'($urandom_range(0, 128)) - 64;
         end
         2: begin
            c.input_pitch = int'($urandom_range(0, 128)) - 64;
            c.output_pitch = int'($urandom_range(0, 128)) - 64;
         end
         default: begin
            c.input_pitch = $urandom();
            c.output_pitch = $urandom();
         end
      endcase
      c.source_offset = $urandom();
      if ($urandom_range(0, 1) == 1) begin
         c.dest_offset = c.source_offset + (int'($urandom_range(0, 64)) - 32);
      end else begin
         c.dest_offset = $urandom();
      end
      return c;
   endfunction

   // One setting, then a few transfers; some are cut short by the next start.
   task automatic run_random_phase(input bit with_gaps);
      cfg_type c;
      int total;
      int steps;
      send_gap_pct = with_gaps ? pick_gap_pct() : 0;
      recv_gap_pct = with_gaps ? pick_gap_pct() : 0;
      c = random_config();
      set_config(c);
      repeat ($urandom_range(1, 4)) begin
         // Stray step: ignored when idle, continues a transfer that was cut short.
         if ($urandom_range(0, 15) == 0) send_item(req_type'{opcode: OP_STEP, same_space: 1'b0});
         start_transfer(1'($urandom_range(0, 1)));
         total = walk_length(c);
         steps = total;
         if (total > 1 && $urandom_range(0, 7) == 0) steps = $urandom_range(1, total - 1);
         step_walk(steps);
      end
   endtask

   // Register settings below list: input pitch, output pitch, line length, line count,
   // input format, output format, source offset, destination offset.

   // Reset values give an empty transfer; a step with nothing armed is ignored.
   task automatic test_reset_defaults();
      send_gap_pct = 25;
      recv_gap_pct = 25;
      send_item(req_type'{opcode: OP_STEP, same_space: 1'b1});
      start_transfer(1'b0);
      start_transfer(1'b1);
   endtask

   // Zero line length and zero line count each answer a no-op.
   task automatic test_empty_transfers();
      set_config(cfg_type'{32'd7, 32'd9, 20'd0, 20'd5, 8'd0, 8'd0, 32'h10, 32'h20});
      start_transfer(1'b1);
      set_config(cfg_type'{32'd7, 32'd9, 20'd5, 20'd0, 8'd0, 8'd0, 32'h10, 32'h20});
      start_transfer(1'b0);
   endtask

   // Largest sizes, strides and offsets; a restart abandons the long walk.
   // Then pitches of minus one make the line bases wrap below zero.
   task automatic test_field_extremes();
      set_config(cfg_type'{32'h8000_0000, 32'h7FFF_FFFF, 20'hF_FFFF, 20'hF_FFFF,
                           8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'h0});
      start_transfer(1'b1);
      step_walk(2);
      set_config(cfg_type'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'd1, 20'hF_FFFF,
                           8'd0, 8'd0, 32'h0, 32'hFFFF_FFFF});
      start_transfer(1'b1);
      step_walk(2);
   endtask

   // Equal pitches matching the line length over the same range: block copy that overlaps.
   task automatic test_block_copy_overlap();
      set_config(cfg_type'{32'd2, 32'd2, 20'd2, 20'd2, 8'd1, 8'd1, 32'h100, 32'h100});
      start_transfer(1'b1);
      step_walk(4);
      send_item(req_type'{opcode: OP_STEP, same_space: 1'b0});
   endtask

   // A source stride of zero counts as one; a destination stride of zero stays on one column.
   task automatic test_byte_strides();
      set_config(cfg_type'{32'd8, 32'd40, 20'd3, 20'd1, 8'd0, 8'd3, 32'h1000, 32'h2000});
      start_transfer(1'b0);
      step_walk(3);
      set_config(cfg_type'{32'd8, 32'd40, 20'd4, 20'd1, 8'd2, 8'd0, 32'h1000, 32'h2000});
      start_transfer(1'b0);
      step_walk(2);
   endtask

   // A shorter line and a single line written mid-transfer end the walk at the next step.
   task automatic test_retune_mid_transfer();
      set_config(cfg_type'{32'd16, 32'hFFFF_FFF0, 20'd6, 20'd3, 8'd1, 8'd0, 32'h400, 32'h800});
      start_transfer(1'b0);
      step_walk(2);
      set_config(cfg_type'{32'd16, 32'hFFFF_FFF0, 20'd2, 20'd1, 8'd1, 8'd0, 32'h400, 32'h800});
      step_walk(1);
   endtask

   task automatic test_random_walks();
      while (walk_items < RANDOM_ITEMS) run_random_phase(1'b1);
   endtask

   // The receiver holds off for a long stretch while steps keep coming.
   task automatic test_back_pressure();
      send_gap_pct = 0;
      recv_gap_pct = 0;
      set_config(cfg_type'{32'd32, 32'd64, 20'd16, 20'd4, 8'd0, 8'd0, 32'h3000, 32'h5000});
      start_transfer(1'b1);
      hold_off_len = HOLD_OFF_CYCLES;
      step_walk(64);
   endtask

   // Final part with no idling on either side.
   task automatic test_streaming();
      while (walk_items < TOTAL_ITEMS) run_random_phase(1'b0);
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_empty_transfers();
      test_field_extremes();
      test_block_copy_overlap();
      test_byte_strides();
      test_retune_mid_transfer();
      test_random_walks();
      test_back_pressure();
      test_streaming();
      wait_idle();
      if (mismatch_count == 0) begin
         $display("strided_2d_copy_address_generator test passed");
      end else begin
         $display("strided_2d_copy_address_generator test failed");
      end
      $finish;
   end

endmodule
